### rtl/upf_pkg.sv
// Shared types, character constants and helpers for the query string parser.
package upf_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_RESULTS = 4;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// Escape progress codes
	localparam logic [1:0] ESC_NONE  = 2'd0;
	localparam logic [1:0] ESC_PCT   = 2'd1;
	localparam logic [1:0] ESC_DIGIT = 2'd2;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_query;
	} upf_in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       in_value;
		logic       key_done;
		logic       pair_done;
		logic       run_last;
	} upf_out_t;

	// All results caused by one input byte, in order; run_last marks the final one
	typedef struct packed {
		upf_out_t [MAX_RESULTS-1:0] res;
	} upf_bundle_t;

	// Bit 4 flags a hex digit, bits 3:0 hold its value
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic upf_out_t mk_res(input logic [7:0] b, input logic has,
			input logic inval, input logic kd, input logic pd);
		upf_out_t r;
		r.data_byte = b;
		r.has_byte  = has;
		r.in_value  = inval;
		r.key_done  = kd;
		r.pair_done = pd;
		r.run_last  = 1'b0;
		return r;
	endfunction

endpackage

### rtl/upf_front.sv
// Front end: accepts raw bytes, tracks segment and escape state, builds result bundles.
module upf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  upf_pkg::upf_in_t     item,
	output logic                 push,
	output upf_pkg::upf_bundle_t bundle
);
	import upf_pkg::*;

	logic [1:0] cnt_q;
	logic [7:0] digit_q;
	logic       value_q;
	logic       started_q;

	logic [1:0]  cnt_d;
	logic [7:0]  digit_d;
	logic        value_d;
	logic        started_d;
	logic [2:0]  n;
	upf_out_t [MAX_RESULTS-1:0] res;
	logic        consumed;
	logic [4:0]  hx_c;
	logic [4:0]  hx_d;
	logic [7:0]  c;

	assign c    = item.char_in;
	assign hx_c = hex_of(c);
	assign hx_d = hex_of(digit_q);

	// Classify the byte and list its results in order
	always_comb begin
		cnt_d     = cnt_q;
		digit_d   = digit_q;
		value_d   = value_q;
		started_d = started_q;
		n         = 3'd0;
		res       = '0;
		consumed  = 1'b0;

		if (c != CH_AMP) begin
			started_d = 1'b1;
			if (cnt_q == ESC_PCT) begin
				if (hx_c[4]) begin
					digit_d  = c;
					cnt_d    = ESC_DIGIT;
					consumed = 1'b1;
				end else begin
					res[n[1:0]] = mk_res(CH_PERCENT, 1'b1, value_d, 1'b0, 1'b0);
					n = n + 3'd1;
					cnt_d   = ESC_NONE;
					digit_d = 8'd0;
				end
			end else if (cnt_q == ESC_DIGIT) begin
				if (hx_d[4] && hx_c[4]) begin
					res[n[1:0]] = mk_res({hx_d[3:0], hx_c[3:0]}, 1'b1, value_d, 1'b0, 1'b0);
					n = n + 3'd1;
					consumed = 1'b1;
				end else begin
					res[n[1:0]] = mk_res(CH_PERCENT, 1'b1, value_d, 1'b0, 1'b0);
					n = n + 3'd1;
					res[n[1:0]] = mk_res(digit_q, 1'b1, value_d, 1'b0, 1'b0);
					n = n + 3'd1;
				end
				cnt_d   = ESC_NONE;
				digit_d = 8'd0;
			end else begin
				cnt_d = ESC_NONE;
			end

			if (!consumed) begin
				if (c == CH_EQUALS && !value_d) begin
					res[n[1:0]] = mk_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
					n = n + 3'd1;
					value_d = 1'b1;
				end else if (c == CH_PERCENT) begin
					cnt_d   = ESC_PCT;
					digit_d = 8'd0;
				end else if (c == CH_PLUS) begin
					res[n[1:0]] = mk_res(CH_SPACE, 1'b1, value_d, 1'b0, 1'b0);
					n = n + 3'd1;
				end else begin
					res[n[1:0]] = mk_res(c, 1'b1, value_d, 1'b0, 1'b0);
					n = n + 3'd1;
				end
			end
		end

		// Close the segment on '&' or at end of query
		if (c == CH_AMP || item.end_of_query) begin
			if (cnt_d == ESC_PCT) begin
				res[n[1:0]] = mk_res(CH_PERCENT, 1'b1, value_d, 1'b0, 1'b0);
				n = n + 3'd1;
			end else if (cnt_d == ESC_DIGIT) begin
				res[n[1:0]] = mk_res(CH_PERCENT, 1'b1, value_d, 1'b0, 1'b0);
				n = n + 3'd1;
				res[n[1:0]] = mk_res(digit_d, 1'b1, value_d, 1'b0, 1'b0);
				n = n + 3'd1;
			end
			if (started_d) begin
				if (!value_d) begin
					res[n[1:0]] = mk_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
				end else begin
					res[n[1:0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b0, 1'b1);
				end
				n = n + 3'd1;
			end
			cnt_d     = ESC_NONE;
			digit_d   = 8'd0;
			value_d   = 1'b0;
			started_d = 1'b0;
		end

		if (n != 3'd0) begin
			res[2'(n - 3'd1)].run_last = 1'b1;
		end
	end

	assign push       = take && (n != 3'd0);
	assign bundle.res = res;

	// Advance parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= ESC_NONE;
			digit_q   <= 8'd0;
			value_q   <= 1'b0;
			started_q <= 1'b0;
		end else if (take) begin
			cnt_q     <= cnt_d;
			digit_q   <= digit_d;
			value_q   <= value_d;
			started_q <= started_d;
		end
	end

endmodule

### rtl/upf_queue.sv
// Short bundle queue between the front end and the back end.
module upf_queue #(
	parameter int Depth = upf_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  upf_pkg::upf_bundle_t wr_data,
	input  logic                 pop,
	output upf_pkg::upf_bundle_t rd_data,
	output logic                 full,
	output logic                 empty
);
	import upf_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	upf_bundle_t         mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

### rtl/upf_back.sv
// Back end: unpacks bundles one result per cycle, while rsp_ready allows, into the output register.
module upf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  upf_pkg::upf_bundle_t head,
	output logic                 pop,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output upf_pkg::upf_out_t    rsp_data
);
	import upf_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	upf_out_t   out_q;
	logic       load;
	upf_out_t   cur;

	assign load      = !valid_q || rsp_ready;
	assign cur       = head.res[idx_q];
	assign pop       = load && !empty && cur.run_last;
	assign rsp_valid = valid_q;
	assign rsp_data  = out_q;

	// Hold the payload until taken, then load the next result
	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_q <= cur;
		end
	end

	// Step through the head bundle and track output occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				idx_q <= cur.run_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

### rtl/form_urlencoded_query_parser_unit.sv
// Top level of the streaming form-urlencoded query string parser.
// A byte's results pass through the queue, then the output register, to reach rsp.
// Throughput: one byte per cycle while the queue is not full, rsp_ready is high and
// each byte yields at most one result; the back end drains one result per cycle, so a
// byte's results leave in turn. Bytes that yield no result never enter the queue.
// Reset: arst_n clears parser state, empties the queue and drops the output register.
module form_urlencoded_query_parser_unit #(
	parameter int QueueDepth = upf_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  upf_pkg::upf_in_t  req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output upf_pkg::upf_out_t rsp_data
);
	import upf_pkg::*;

	logic        take;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	upf_bundle_t wr_bundle;
	upf_bundle_t head;

	assign req_ready = !full;
	assign take      = req_valid && req_ready;

	upf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (req_data),
		.push   (push),
		.bundle (wr_bundle)
	);

	upf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_bundle),
		.pop     (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	upf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// Never drain a bundle from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("bundle popped from empty queue");

	// A pair end is always the final result of its byte
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.pair_done) |-> rsp_data.run_last)
		else $error("pair_done result not marked run_last");

	// Every result carries either a byte or a marker
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.has_byte || rsp_data.key_done || rsp_data.pair_done))
		else $error("empty result emitted");

	// A byte result never carries a marker
	a_byte_no_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.has_byte) |-> (!rsp_data.key_done && !rsp_data.pair_done))
		else $error("byte result carries a marker");

endmodule
